// ----- rtl/fir_lowpass_55tap_defines.svh -----
// Assertion macros for the verification-side checker of the FIR block.
// No dependencies; macros expect signals named clk and rst in scope.
`ifndef FIR_LOWPASS_55TAP_DEFINES_SVH
`define FIR_LOWPASS_55TAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/flp_pkg.sv -----
// Package for the 55-tap low-pass FIR: coefficient ROM, microcode format and program.
// No dependencies.
package flp_pkg;

  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 15;
  localparam int ROM_DEPTH  = 64;
  localparam int COEF_IDX_W = 6;
  localparam int STEP_W     = 3;

  // Symmetric low-pass taps in Q1.15, zero padded to the ROM depth.
  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_DEPTH] = '{
    -16'sd24,   -16'sd31,   -16'sd40,   -16'sd39,   -16'sd23,
     16'sd13,    16'sd69,    16'sd140,   16'sd212,   16'sd266,
     16'sd281,   16'sd237,   16'sd124,  -16'sd55,   -16'sd279,
    -16'sd511,  -16'sd697,  -16'sd778,  -16'sd699,  -16'sd421,
     16'sd70,    16'sd755,   16'sd1580,  16'sd2462,  16'sd3302,
     16'sd3994,  16'sd4450,  16'sd4609,  16'sd4450,  16'sd3994,
     16'sd3302,  16'sd2462,  16'sd1580,  16'sd755,   16'sd70,
    -16'sd421,  -16'sd699,  -16'sd778,  -16'sd697,  -16'sd511,
    -16'sd279,  -16'sd55,    16'sd124,   16'sd237,   16'sd281,
     16'sd266,   16'sd212,   16'sd140,   16'sd69,    16'sd13,
    -16'sd23,   -16'sd39,   -16'sd40,   -16'sd31,   -16'sd24,
     16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
     16'sd0,     16'sd0,     16'sd0,     16'sd0
  };

  // Step addresses of the control program.
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_MAC    = 3'd1;
  localparam logic [STEP_W-1:0] ST_DRAIN0 = 3'd2;
  localparam logic [STEP_W-1:0] ST_DRAIN1 = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd4;

  // Branch conditions: taken -> tgt_t, else tgt_f.
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_MORE_TAPS,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic              ready;   // input channel open
    logic              start;   // on accept: set read index and tap count, clear accumulator
    logic              issue;   // read one tap, step the read index
    logic              emit;    // round, saturate, load the output register
    cond_t             cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ucw_t;

  function automatic ucw_t uc_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{ready: 1'b0, start: 1'b0, issue: 1'b0, emit: 1'b0,
          cond: COND_NEVER, tgt_t: ST_IDLE, tgt_f: ST_IDLE};
    case (step)
      ST_IDLE: begin
        w.ready = 1'b1;
        w.start = 1'b1;
        w.cond  = COND_NO_INPUT;
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_MAC;
      end
      ST_MAC: begin
        w.issue = 1'b1;
        w.cond  = COND_MORE_TAPS;
        w.tgt_t = ST_MAC;
        w.tgt_f = ST_DRAIN0;
      end
      ST_DRAIN0: begin
        w.tgt_f = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        w.tgt_f = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit  = 1'b1;
        w.cond  = COND_OUT_BUSY;
        w.tgt_t = ST_EMIT;
        w.tgt_f = ST_IDLE;
      end
      default: begin
        w.tgt_f = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/flp_in_if.sv -----
// Input sample channel: valid/ready handshake with a signed sample payload.
// No dependencies.
interface flp_in_if #(
  parameter int WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/flp_out_if.sv -----
// Output sample channel: valid/ready handshake with a signed sample payload.
// No dependencies.
interface flp_out_if #(
  parameter int WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/fir_lowpass_55tap.sv -----
// 55-tap direct-form low-pass FIR, one filtered sample per input sample.
// Depends on flp_pkg, flp_in_if, flp_out_if and flp_ram.
//
// Usage:
//  - in_ch carries one signed Q15 sample per transaction (valid/ready).
//  - out_ch returns one signed Q15 sample per input, rounded half up and
//    saturated, in input order.
//  - One sample is processed at a time: after an input transaction, ready
//    stays low through the MAC, DRAIN0, DRAIN1 and EMIT steps, so a new
//    sample is taken only once the last one is through. The single shared
//    multiply-accumulate works through the taps, one tap per cycle.
//  - The result is loaded into the output register in the EMIT step, after
//    the MAC, DRAIN0 and DRAIN1 steps that follow the input transaction.
//  - The output is registered; the next sample can be accepted while a
//    result waits. If the receiver keeps stalling, the following result
//    holds the sequencer until the output register frees up, and the
//    input stays closed meanwhile.
//  - Reset (rst, synchronous) keeps ready low, empties the output register,
//    zeroes the write pointer and marks all delay-line entries as empty;
//    empty entries read as zero, so no clearing pass is needed.
module fir_lowpass_55tap #(
  parameter int TAPS         = 55,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  flp_in_if.sink    in_ch,
  flp_out_if.source out_ch
);
  import flp_pkg::*;

  localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + COEF_IDX_W;    // room for ROM_DEPTH full-scale terms
  localparam int RND_W  = ACC_W + 1;
  localparam int Q_W    = RND_W - COEF_FRAC;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
  localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  // Sequencer
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucw_t              uc;
  logic              cond_hit;
  logic              accept;
  logic              out_busy;
  logic              emit;

  // Delay line addressing
  logic [IDX_W-1:0]  wp;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cnt;
  logic [TAPS-1:0]   entry_vld;

  // MAC datapath
  logic [SAMPLE_WIDTH-1:0]        ram_q;
  logic                           entry_vld_q;
  logic signed [COEF_W-1:0]       coef_q;
  logic                           issue_d1;
  logic signed [SAMPLE_WIDTH-1:0] tap_x;
  logic signed [PROD_W-1:0]       prod;
  logic                           prod_vld;
  logic signed [ACC_W-1:0]        acc;

  // Rounding / saturation
  logic signed [RND_W-1:0]        rnd;
  logic signed [Q_W-1:0]          q;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  // Output register
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_data;

  assign uc       = uc_rom(pc);
  assign accept   = uc.ready & ~rst & in_ch.valid;
  assign out_busy = out_valid & ~out_ch.ready;
  assign emit     = uc.emit & ~out_busy;

  always_comb begin
    case (uc.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_NO_INPUT:  cond_hit = ~in_ch.valid;
      COND_MORE_TAPS: cond_hit = (cnt != LAST_IDX);
      COND_OUT_BUSY:  cond_hit = out_busy;
      default:        cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? uc.tgt_t : uc.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Sample storage: written on accept, read one tap per MAC step.
  flp_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TAPS)
  ) u_dline (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (in_ch.sample_in),
    .re    (uc.issue),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Per-entry written flags stand in for clearing the delay line.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      wp        <= '0;
    end else if (accept) begin
      entry_vld[wp] <= 1'b1;
      wp            <= (wp == LAST_IDX) ? '0 : IDX_W'(wp + 1'b1);
    end
  end

  // Read index walks from newest to oldest; cnt selects the coefficient.
  always_ff @(posedge clk) begin
    if (accept && uc.start) begin
      rd_idx <= wp;
      cnt    <= '0;
    end else if (uc.issue) begin
      rd_idx <= (rd_idx == '0) ? LAST_IDX : IDX_W'(rd_idx - 1'b1);
      cnt    <= IDX_W'(cnt + 1'b1);
    end
  end

  // Coefficient and written flag travel with the RAM read.
  always_ff @(posedge clk) begin
    if (uc.issue) begin
      entry_vld_q <= entry_vld[rd_idx];
      coef_q      <= COEF_ROM[COEF_IDX_W'(cnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d1 <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      issue_d1 <= uc.issue;
      prod_vld <= issue_d1;
    end
  end

  assign tap_x = entry_vld_q ? $signed(ram_q) : '0;

  always_ff @(posedge clk) begin
    if (issue_d1) begin
      prod <= tap_x * coef_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && uc.start) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up, floor shift back to Q15, clamp.
  always_comb begin
    rnd = RND_W'(acc) + HALF_LSB;
    q   = $signed(rnd[RND_W-1:COEF_FRAC]);
    if (q > Q_MAX) begin
      sat_val = SAMPLE_WIDTH'(Q_MAX);
    end else if (q < Q_MIN) begin
      sat_val = SAMPLE_WIDTH'(Q_MIN);
    end else begin
      sat_val = SAMPLE_WIDTH'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= sat_val;
    end
  end

  assign in_ch.ready       = uc.ready & ~rst;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;

endmodule

// ----- rtl/flp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/flp_checker.sv -----
// Port-level checks for fir_lowpass_55tap, attached by bind.
// Depends on fir_lowpass_55tap_defines.svh and fir_lowpass_55tap.
`include "fir_lowpass_55tap_defines.svh"

module flp_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);
  // stalled result holds
  `FLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out), "output changed while stalled")
  // one sample in flight: input closes after a transaction
  `FLP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted twice in a row")
  // idle sequencer stays open until a sample comes
  `FLP_ASSERT_NEXT(a_idle_waits, in_ready && !in_valid, in_ready, "input closed with no transaction")
  // a new result is loaded only from the busy phase
  `FLP_ASSERT_NOW(a_result_after_work, $rose(out_valid), !$past(in_ready), "result appeared while idle")
endmodule

bind fir_lowpass_55tap flp_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_flp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out)
);
